// File: rtl/ntt9_pkg.sv
// shared types and constants for the 9-point radix-3 ntt, modulus 3457
// no dependencies

package ntt9_pkg;

    typedef logic signed [15:0] t_coef;

    localparam int NUM_ROWS   = 9;
    localparam int NUM_TW     = 8;
    localparam int CFG_IDX_W  = $clog2(NUM_TW);

    // montgomery constants: q * qinv == 1 mod 2^16
    localparam logic [15:0]  QINV  = 16'd12929;
    localparam t_coef        QMOD  = 16'sd3457;
    localparam t_coef        KAPPA = -16'sd886;

    // pipeline depths of one montgomery multiplier and one butterfly
    localparam int MONT_LAT = 3;
    localparam int BFLY_LAT = 2 * MONT_LAT + 1;

    // twiddle register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        TW_A0 = 3'd0,
        TW_A1 = 3'd1,
        TW_B0 = 3'd2,
        TW_B1 = 3'd3,
        TW_C0 = 3'd4,
        TW_C1 = 3'd5,
        TW_D0 = 3'd6,
        TW_D1 = 3'd7
    } t_tw_idx;

endpackage

// File: rtl/ntt9_in_if.sv
// input channel: valid/ready with nine signed coefficients
// depends on ntt9_pkg

interface ntt9_in_if import ntt9_pkg::*; ();
    logic  valid;
    logic  ready;
    t_coef x0, x1, x2, x3, x4, x5, x6, x7, x8;

    modport source (output valid, x0, x1, x2, x3, x4, x5, x6, x7, x8, input ready);
    modport sink   (input valid, x0, x1, x2, x3, x4, x5, x6, x7, x8, output ready);
endinterface

// File: rtl/ntt9_out_if.sv
// output channel: valid/ready with nine transformed coefficients
// depends on ntt9_pkg

interface ntt9_out_if import ntt9_pkg::*; ();
    logic  valid;
    logic  ready;
    t_coef y0, y1, y2, y3, y4, y5, y6, y7, y8;

    modport source (output valid, y0, y1, y2, y3, y4, y5, y6, y7, y8, input ready);
    modport sink   (input valid, y0, y1, y2, y3, y4, y5, y6, y7, y8, output ready);
endinterface

// File: rtl/ntt9_mont.sv
// three-stage signed montgomery multiplier: product, m = v*qinv, (v - m*q) >> 16
// depends on ntt9_pkg

module ntt9_mont import ntt9_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_coef i_a,
    input  t_coef i_b,
    output t_coef o_r
);

    logic signed [31:0] r_v;
    logic signed [31:0] r_v2;
    t_coef              r_m;
    t_coef              r_r;

    logic signed [31:0] n_v;
    t_coef              n_m;
    logic signed [31:0] n_d;

    assign n_v = 32'(i_a) * 32'(i_b);
    assign n_m = t_coef'(32'(r_v[15:0]) * 32'(QINV));
    // low half of n_d is zero by construction, the shift is exact
    assign n_d = r_v2 - 32'(r_m) * 32'(QMOD);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v  <= n_v;
            r_v2 <= r_v;
            r_m  <= n_m;
            r_r  <= t_coef'(n_d[31:16]);
        end
    end

    assign o_r = r_r;

endmodule

// File: rtl/ntt9_bfly.sv
// pipelined radix-3 butterfly: two twiddle products, kappa product, final sums
// depends on ntt9_pkg, ntt9_mont

module ntt9_bfly import ntt9_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_coef i_a,
    input  t_coef i_b,
    input  t_coef i_c,
    input  t_coef i_z1,
    input  t_coef i_z2,
    output t_coef o_a,
    output t_coef o_b,
    output t_coef o_c
);

    localparam int ADLY = 2 * MONT_LAT;

    t_coef w_t1, w_t2, w_t3;
    t_coef n_diff;

    t_coef r_a_dly  [ADLY];
    t_coef r_t1_dly [MONT_LAT];
    t_coef r_t2_dly [MONT_LAT];
    t_coef r_oa, r_ob, r_oc;

    ntt9_mont u_t1 (.i_clk(i_clk), .i_en(i_en), .i_a(i_z1), .i_b(i_b), .o_r(w_t1));
    ntt9_mont u_t2 (.i_clk(i_clk), .i_en(i_en), .i_a(i_z2), .i_b(i_c), .o_r(w_t2));

    assign n_diff = w_t1 - w_t2;

    ntt9_mont u_t3 (.i_clk(i_clk), .i_en(i_en), .i_a(KAPPA), .i_b(n_diff), .o_r(w_t3));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_dly[0]  <= i_a;
            for (int k = 1; k < ADLY; k++) begin
                r_a_dly[k] <= r_a_dly[k-1];
            end
            r_t1_dly[0] <= w_t1;
            r_t2_dly[0] <= w_t2;
            for (int k = 1; k < MONT_LAT; k++) begin
                r_t1_dly[k] <= r_t1_dly[k-1];
                r_t2_dly[k] <= r_t2_dly[k-1];
            end
            r_oa <= r_a_dly[ADLY-1] + r_t1_dly[MONT_LAT-1] + r_t2_dly[MONT_LAT-1];
            r_ob <= r_a_dly[ADLY-1] - r_t2_dly[MONT_LAT-1] + w_t3;
            r_oc <= r_a_dly[ADLY-1] - r_t1_dly[MONT_LAT-1] - w_t3;
        end
    end

    assign o_a = r_oa;
    assign o_b = r_ob;
    assign o_c = r_oc;

endmodule

// File: rtl/ntt9_radix3_montgomery.sv
// channel  | dir | handshake        | payload
// i_in     | in  | valid / ready    | x0..x8, signed 16-bit
// o_out    | out | valid / ready    | y0..y8, signed 16-bit
// i_cfg    | in  | write enable     | i_cfg_idx (3 bits), i_cfg_data (16 bits)
//
// the pipeline is two butterfly layers of 7 stages each (the two twiddle
// montgomery units of 3 stages side by side, then the kappa unit of 3, plus one sum stage)
// one item is accepted per cycle unless stalled; the whole pipeline advances on one enable
// that is high while the output register is empty or being taken
// a stall freezes every stage in place, so nothing is dropped or repeated
// synchronous reset clears valid bits and twiddles; payload registers are not reset
// depends on ntt9_pkg, ntt9_in_if, ntt9_out_if, ntt9_bfly

module ntt9_radix3_montgomery import ntt9_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    ntt9_in_if.sink              i_in,
    ntt9_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_coef                i_cfg_data
);

    localparam int PIPE_LAT = 2 * BFLY_LAT;

    t_coef                 r_tw [NUM_TW];
    logic  [PIPE_LAT-1:0]  r_valid;
    logic                  w_en;

    t_coef w_x  [NUM_ROWS];
    t_coef w_l1 [3][3];
    t_coef w_l2 [3][3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_TW; k++) begin
                r_tw[k] <= '0;
            end
        end else if (i_cfg_we) begin
            r_tw[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign w_en = !r_valid[PIPE_LAT-1] || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[PIPE_LAT-2:0], i_in.valid};
        end
    end

    assign i_in.ready = w_en;

    assign w_x[0] = i_in.x0;
    assign w_x[1] = i_in.x1;
    assign w_x[2] = i_in.x2;
    assign w_x[3] = i_in.x3;
    assign w_x[4] = i_in.x4;
    assign w_x[5] = i_in.x5;
    assign w_x[6] = i_in.x6;
    assign w_x[7] = i_in.x7;
    assign w_x[8] = i_in.x8;

    // first layer: rows (g, g+3, g+6)
    // second layer: rows (3g, 3g+1, 3g+2), which are output g of each first-layer butterfly
    for (genvar g = 0; g < 3; g++) begin : g_layer
        ntt9_bfly u_l1 (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_x[g]),
            .i_b   (w_x[g+3]),
            .i_c   (w_x[g+6]),
            .i_z1  (r_tw[TW_A0]),
            .i_z2  (r_tw[TW_A1]),
            .o_a   (w_l1[g][0]),
            .o_b   (w_l1[g][1]),
            .o_c   (w_l1[g][2])
        );

        ntt9_bfly u_l2 (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_a   (w_l1[0][g]),
            .i_b   (w_l1[1][g]),
            .i_c   (w_l1[2][g]),
            .i_z1  (r_tw[TW_B0 + 2 * g]),
            .i_z2  (r_tw[TW_B1 + 2 * g]),
            .o_a   (w_l2[g][0]),
            .o_b   (w_l2[g][1]),
            .o_c   (w_l2[g][2])
        );
    end

    assign o_out.valid = r_valid[PIPE_LAT-1];
    assign o_out.y0    = w_l2[0][0];
    assign o_out.y1    = w_l2[0][1];
    assign o_out.y2    = w_l2[0][2];
    assign o_out.y3    = w_l2[1][0];
    assign o_out.y4    = w_l2[1][1];
    assign o_out.y5    = w_l2[1][2];
    assign o_out.y6    = w_l2[2][0];
    assign o_out.y7    = w_l2[2][1];
    assign o_out.y8    = w_l2[2][2];

endmodule

// File: rtl/ntt9_chk.sv
// port-level checks for the ntt pipeline, attached to the top level by bind
// depends on ntt9_radix3_montgomery

module ntt9_chk (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_in_valid,
    input logic         i_in_ready,
    input logic         i_out_valid,
    input logic         i_out_ready,
    input logic [143:0] i_out_data
);

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled output item changed");

    // the pipeline accepts whenever its output is free or being drained
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output state");

    // reset leaves no item in flight
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // an offered output item carries a fully known payload
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown(i_out_data))
        else $error("output item with unknown payload");

endmodule

bind ntt9_radix3_montgomery ntt9_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  ({o_out.y0, o_out.y1, o_out.y2, o_out.y3, o_out.y4,
                   o_out.y5, o_out.y6, o_out.y7, o_out.y8})
);

// File: tb/tb_ntt9_radix3_montgomery.sv
`timescale 1ns / 100ps
// testbench for ntt9_radix3_montgomery: streams lanes, predicts every transform, checks each one
// depends on ntt9_pkg, ntt9_in_if, ntt9_out_if and the rtl of ntt9_radix3_montgomery

module tb_ntt9_radix3_montgomery;
    import ntt9_pkg::*;

    typedef logic [NUM_ROWS-1:0][15:0] t_lane;

    localparam longint MODULUS       = 3457;
    localparam longint MONT_QINV     = 12929;
    localparam t_coef  BFLY_KAPPA    = -16'sd886;
    localparam int     SETTLE_CYCLES = 2 * BFLY_LAT + 6;
    localparam int     ITEMS_PER_CFG = 185;
    localparam int     MAX_SHOWN     = 40;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    t_coef                i_cfg_data = '0;

    ntt9_in_if  in_ch ();
    ntt9_out_if out_ch ();

    ntt9_radix3_montgomery dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_coef tw_model [NUM_TW];
    t_lane lanes_to_send [$];
    t_lane predicted_spectra [$];
    int    lanes_queued = 0;
    int    lanes_accepted = 0;
    int    spectra_checked = 0;
    int    mismatches = 0;
    int    shown = 0;
    int    cfg_sets = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    logic  in_taken = 1'b0;

    initial begin
        in_ch.valid = 1'b0;
        {in_ch.x0, in_ch.x1, in_ch.x2, in_ch.x3, in_ch.x4} = '0;
        {in_ch.x5, in_ch.x6, in_ch.x7, in_ch.x8} = '0;
        out_ch.ready = 1'b0;
    end

    // signed montgomery product, floor shift by 16
    function automatic t_coef mont_product(t_coef a, t_coef b);
        longint prod;
        longint lowmul;
        longint diff;
        t_coef  m;
        prod   = longint'(a) * longint'(b);
        lowmul = prod * MONT_QINV;
        m      = lowmul[15:0];
        diff   = prod - longint'(m) * MODULUS;
        diff   = diff >>> 16;
        return diff[15:0];
    endfunction

    function automatic logic [2:0][15:0] radix3_bfly(t_coef a, t_coef b, t_coef c,
                                                     t_coef z1, t_coef z2);
        t_coef t1;
        t_coef t2;
        t_coef t3;
        t_coef d;
        logic [2:0][15:0] res;
        t1 = mont_product(z1, b);
        t2 = mont_product(z2, c);
        d  = t1 - t2;
        t3 = mont_product(BFLY_KAPPA, d);
        res[0] = a + t1 + t2;
        res[1] = a - t2 + t3;
        res[2] = a - t1 - t3;
        return res;
    endfunction

    function automatic t_lane ntt9_transform(t_lane x);
        t_lane r;
        logic [2:0][15:0] trip;
        t_coef zmid [3];
        t_coef zlast [3];
        r = x;
        zmid[0] = tw_model[TW_B0];
        zlast[0] = tw_model[TW_B1];
        zmid[1] = tw_model[TW_C0];
        zlast[1] = tw_model[TW_C1];
        zmid[2] = tw_model[TW_D0];
        zlast[2] = tw_model[TW_D1];
        // columns first, then rows of three
        for (int g = 0; g < 3; g++) begin
            trip = radix3_bfly(r[g], r[g+3], r[g+6], tw_model[TW_A0], tw_model[TW_A1]);
            r[g] = trip[0];
            r[g+3] = trip[1];
            r[g+6] = trip[2];
        end
        for (int g = 0; g < 3; g++) begin
            trip = radix3_bfly(r[3*g], r[3*g+1], r[3*g+2], zmid[g], zlast[g]);
            r[3*g] = trip[0];
            r[3*g+1] = trip[1];
            r[3*g+2] = trip[2];
        end
        return r;
    endfunction

    function automatic t_coef rand_coef();
        int pick;
        pick = $urandom_range(9);
        case (pick)
            5, 6, 7: begin
                return t_coef'($urandom_range(2 * MODULUS) - MODULUS);
            end
            8: begin
                case ($urandom_range(3))
                    0: return 16'sh7fff;
                    1: return -16'sh8000;
                    2: return 16'sd0;
                    default: return -16'sd1;
                endcase
            end
            9: begin
                return t_coef'($urandom_range(16) - 8);
            end
            default: begin
                return t_coef'($urandom);
            end
        endcase
    endfunction

    // scoreboard: twiddle shadow, prediction on input accept, check on output accept
    always @(posedge i_clk) begin
        t_lane lane;
        t_lane got;
        t_lane want;
        if (!i_rst_n) begin
            foreach (tw_model[k]) tw_model[k] = '0;
        end else if (i_cfg_we) begin
            tw_model[t_tw_idx'(i_cfg_idx)] = i_cfg_data;
        end
        in_taken <= i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            lane = {in_ch.x8, in_ch.x7, in_ch.x6, in_ch.x5, in_ch.x4,
                    in_ch.x3, in_ch.x2, in_ch.x1, in_ch.x0};
            predicted_spectra.push_back(ntt9_transform(lane));
            lanes_accepted++;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.y8, out_ch.y7, out_ch.y6, out_ch.y5, out_ch.y4,
                   out_ch.y3, out_ch.y2, out_ch.y1, out_ch.y0};
            spectra_checked++;
            if (predicted_spectra.size() == 0) begin
                mismatches++;
                if (shown < MAX_SHOWN) begin
                    shown++;
                    $display("%0t: item with none expected, got %h", $time, got);
                end
            end else begin
                want = predicted_spectra.pop_front();
                for (int i = 0; i < NUM_ROWS; i++) begin
                    if (got[i] !== want[i]) begin
                        mismatches++;
                        if (shown < MAX_SHOWN) begin
                            shown++;
                            $display("%0t: y%0d expected %0d got %0d", $time, i,
                                     $signed(want[i]), $signed(got[i]));
                        end
                    end
                end
            end
        end
    end

    // driver and receiver, both change on the falling edge
    always @(negedge i_clk) begin
        t_lane nxt;
        if (!in_ch.valid || in_taken) begin
            if (lanes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = lanes_to_send.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.x0 <= nxt[0];
                in_ch.x1 <= nxt[1];
                in_ch.x2 <= nxt[2];
                in_ch.x3 <= nxt[3];
                in_ch.x4 <= nxt[4];
                in_ch.x5 <= nxt[5];
                in_ch.x6 <= nxt[6];
                in_ch.x7 <= nxt[7];
                in_ch.x8 <= nxt[8];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic queue_lane(t_lane l);
        lanes_to_send.push_back(l);
        lanes_queued++;
    endtask

    task automatic queue_fill(t_coef v);
        t_lane l;
        for (int i = 0; i < NUM_ROWS; i++) l[i] = v;
        queue_lane(l);
    endtask

    // sender holds off until every item is back and the pipeline has emptied
    task automatic wait_idle();
        while (lanes_accepted != lanes_queued || predicted_spectra.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_twiddles(t_coef vals [NUM_TW]);
        for (int i = 0; i < NUM_TW; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_tw_idx'(i);
            i_cfg_data <= vals[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    initial begin
        t_coef tw [NUM_TW];
        t_lane l;
        int    kind;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // twiddles at reset: every product vanishes
        cfg_sets = 1;
        queue_fill(16'sd0);
        queue_fill(16'sh7fff);
        queue_fill(-16'sh8000);
        wait_idle();

        foreach (tw[k]) tw[k] = 16'sh7fff;
        write_twiddles(tw);
        queue_fill(16'sh7fff);
        queue_fill(-16'sh8000);
        queue_fill(-16'sd1);
        queue_fill(16'sd1);
        for (int i = 0; i < NUM_ROWS; i++) l[i] = i[0] ? 16'h8000 : 16'h7fff;
        queue_lane(l);
        // single row set, one per row
        for (int r = 0; r < NUM_ROWS; r++) begin
            l = '0;
            l[r] = 16'(MODULUS);
            queue_lane(l);
        end
        wait_idle();

        foreach (tw[k]) tw[k] = -16'sh8000;
        write_twiddles(tw);
        queue_fill(16'sh7fff);
        queue_fill(-16'sh8000);
        for (int i = 0; i < NUM_ROWS; i++) l[i] = i[0] ? 16'h7fff : 16'h8000;
        queue_lane(l);
        wait_idle();

        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int half = 0; half < 2; half++) begin
                kind = $urandom_range(2);
                foreach (tw[k]) begin
                    case (kind)
                        0: tw[k] = t_coef'($urandom);
                        1: tw[k] = t_coef'($urandom_range(2 * MODULUS) - MODULUS);
                        default: tw[k] = rand_coef();
                    endcase
                end
                write_twiddles(tw);
                for (int n = 0; n < ITEMS_PER_CFG; n++) begin
                    for (int i = 0; i < NUM_ROWS; i++) l[i] = rand_coef();
                    queue_lane(l);
                end
                wait_idle();
            end
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;

        $display("%0d lanes transformed and checked over %0d twiddle settings", spectra_checked,
                 cfg_sets);
        $display("idle mixes: none, sender 52%%, receiver 52%%, both 12%%");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #400000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
